/* rtl/core/hkv_pkg.sv */
// Package for the hashed key/value table: codes, state type, hash primes,
// tag constants and parameter defaults. No dependencies.
`timescale 1ns / 1ps
package hkv_pkg;

  localparam int CAPACITY_DEF    = 1024;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int VALUE_BYTES_DEF = 8;
  localparam int TOTAL_W         = 11;

  localparam logic [31:0] PR1 = 32'h9E3779B1;
  localparam logic [31:0] PR2 = 32'h85EBCA77;
  localparam logic [31:0] PR3 = 32'hC2B2AE3D;
  localparam logic [31:0] PR4 = 32'h27D4EB2F;
  localparam logic [31:0] PR5 = 32'h165667B1;

  localparam logic [6:0] TAG_LOW = 7'h7f;
  localparam logic [7:0] TAG_SET = 8'h80;
  localparam logic [7:0] TAG_EMPTY = 8'h00;

  typedef enum logic [2:0] {
    MODE_FIND    = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_REMOVE  = 3'd2,
    MODE_NEXT    = 3'd3,
    MODE_RESTART = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_DEL_RD,
    S_DEL_CHK,
    S_DEL_HASH,
    S_DEL_END,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DONE
  } state_e;

endpackage

/* rtl/core/hashed_key_value_table.sv */
// Top level: sequencer over the slot memory and the shared hash unit.
// Depends on hkv_pkg, hkv_hash, hkv_store.
//
//   port group        dir   timing
//   start/mode/key/   in    word taken when start high and busy low
//   value_in
//   done/status/...   out   done a one-cycle strobe, receiver cannot stall
//
// After reset a clearing pass writes every tag empty, one slot a cycle,
// with busy high. A find or insert hashes the key, then reads and checks
// one slot per probe, then gives the result; a removal then reads, checks
// and rehashes each following slot, moving entries back into the hole, and
// writes the last hole empty to close the chain. A scan step reads and checks
// each slot visited, then gives the result. The hash unit has a single
// multiplier and the memory a single read port. Busy stays high until done.
`timescale 1ns / 1ps
module hashed_key_value_table #(
  parameter int CAPACITY    = hkv_pkg::CAPACITY_DEF,
  parameter int KEY_BYTES   = hkv_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BYTES = hkv_pkg::VALUE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_in_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] value_out_o,
  output logic [63:0] key_out_o,
  output logic [10:0] entry_total_o
);
  import hkv_pkg::*;

  localparam int IW    = $clog2(CAPACITY);
  localparam int CW    = IW + 1;
  localparam int KW    = 8 * KEY_BYTES;
  localparam int VW    = 8 * VALUE_BYTES;
  localparam int ENT_W = 8 + KW + VW;

  state_e state_q, state_d;

  logic [IW-1:0] clr_q, p_q, hole_q, j_q;
  logic [CW-1:0] cnt_q, count_q, scan_q;
  logic [7:0]    fp_q;
  mode_e         mode_q;
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q, vout_q;
  logic [KW-1:0] kout_q;
  status_e       status_q;
  logic [ENT_W-1:0] ent_q;

  // memory and hash hookup
  logic             mem_we;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata, rdata;
  logic             h_start, h_done;
  logic [KW-1:0]    h_key;
  logic [31:0]      h_out;

  logic [7:0]    r_tag;
  logic [KW-1:0] r_key;
  logic [VW-1:0] r_val;
  logic          hit, probe_last, tbl_full, scan_end, shift_ok;
  logic [IW-1:0] home;
  mode_e         mode_in;

  assign mode_in    = mode_e'(mode_i);
  assign r_tag      = rdata[ENT_W-1 -: 8];
  assign r_key      = rdata[VW +: KW];
  assign r_val      = rdata[VW-1:0];
  assign hit        = (r_tag == fp_q) && (r_key == key_q);
  assign probe_last = (cnt_q == CW'(CAPACITY - 1));
  assign tbl_full   = (count_q >= CW'(CAPACITY));
  assign scan_end   = (scan_q == CW'(CAPACITY));
  assign home       = h_out[IW-1:0];
  // keep the entry where it is if the hole lies outside its probe run
  assign shift_ok   = ((j_q - home) >= (j_q - hole_q));

  hkv_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(h_start),
    .key_i  (h_key),
    .done_o (h_done),
    .hash_o (h_out)
  );

  hkv_store #(.DEPTH(CAPACITY), .WIDTH(ENT_W)) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == IW'(CAPACITY - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          unique case (mode_in)
            MODE_FIND, MODE_REMOVE: state_d = S_HASH;
            MODE_INSERT: state_d = tbl_full ? S_DONE : S_HASH;
            MODE_NEXT: state_d = scan_end ? S_DONE : S_SCAN_RD;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_HASH: begin
        if (h_done) state_d = S_PROBE_RD;
      end
      S_PROBE_RD: state_d = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (r_tag == TAG_EMPTY) begin
          state_d = S_DONE;
        end else if (mode_q != MODE_INSERT && hit) begin
          state_d = (mode_q == MODE_REMOVE) ? S_DEL_RD : S_DONE;
        end else begin
          state_d = probe_last ? S_DONE : S_PROBE_RD;
        end
      end
      S_DEL_RD: state_d = (cnt_q == CW'(CAPACITY)) ? S_DEL_END : S_DEL_CHK;
      S_DEL_CHK: state_d = (r_tag == TAG_EMPTY) ? S_DEL_END : S_DEL_HASH;
      S_DEL_HASH: begin
        if (h_done) state_d = S_DEL_RD;
      end
      S_DEL_END: state_d = S_DONE;
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (r_tag != TAG_EMPTY || scan_end) state_d = S_DONE;
        else state_d = S_SCAN_RD;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs to memory, hash unit and ports
  always_comb begin
    busy      = (state_q != S_IDLE);
    done_o    = (state_q == S_DONE);
    h_start   = 1'b0;
    h_key     = key_i[KW-1:0];
    mem_we    = 1'b0;
    mem_waddr = p_q;
    mem_wdata = '0;
    mem_raddr = p_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      S_IDLE: begin
        h_start = start && (mode_in == MODE_FIND || mode_in == MODE_REMOVE ||
                            (mode_in == MODE_INSERT && !tbl_full));
      end
      S_PROBE_CHK: begin
        if (mode_q == MODE_INSERT && r_tag == TAG_EMPTY) begin
          mem_we    = 1'b1;
          mem_wdata = {fp_q, key_q, val_q};
        end
      end
      S_DEL_RD: mem_raddr = j_q + 1'b1;
      S_DEL_CHK: begin
        h_key   = r_key;
        h_start = (r_tag != TAG_EMPTY);
      end
      S_DEL_HASH: begin
        mem_waddr = hole_q;
        mem_wdata = ent_q;
        mem_we    = h_done && shift_ok;
      end
      S_DEL_END: begin
        mem_we    = 1'b1;
        mem_waddr = hole_q;
      end
      S_SCAN_RD: mem_raddr = scan_q[IW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      count_q <= '0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == S_IDLE && start && mode_in == MODE_RESTART) scan_q <= '0;
      if (state_q == S_SCAN_RD) scan_q <= scan_q + 1'b1;
      if (state_q == S_PROBE_CHK && mode_q == MODE_INSERT && r_tag == TAG_EMPTY) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == S_DEL_END && count_q != '0) count_q <= count_q - 1'b1;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          mode_q <= mode_in;
          key_q  <= key_i[KW-1:0];
          val_q  <= value_in_i[VW-1:0];
          vout_q <= '0;
          kout_q <= '0;
          if (mode_in == MODE_INSERT && tbl_full) status_q <= ST_FULL;
          else if (mode_in == MODE_NEXT) status_q <= ST_ABSENT;
          else status_q <= ST_OK;
        end
      end
      S_HASH: begin
        if (h_done) begin
          fp_q  <= {1'b1, h_out[6:0] & TAG_LOW};
          p_q   <= home;
          cnt_q <= '0;
        end
      end
      S_PROBE_CHK: begin
        if (r_tag == TAG_EMPTY) begin
          if (mode_q != MODE_INSERT) status_q <= ST_ABSENT;
        end else if (mode_q != MODE_INSERT && hit) begin
          vout_q <= r_val;
          hole_q <= p_q;
          j_q    <= p_q;
          cnt_q  <= CW'(1);
        end else begin
          if (probe_last) status_q <= (mode_q == MODE_INSERT) ? ST_FULL : ST_ABSENT;
          p_q   <= p_q + 1'b1;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      S_DEL_RD: j_q <= j_q + 1'b1;
      S_DEL_CHK: ent_q <= rdata;
      S_DEL_HASH: begin
        if (h_done) begin
          if (shift_ok) hole_q <= j_q;
          cnt_q <= cnt_q + 1'b1;
        end
      end
      S_SCAN_CHK: begin
        if (r_tag != TAG_EMPTY) begin
          status_q <= ST_OK;
          vout_q   <= r_val;
          kout_q   <= r_key;
        end
      end
      default: ;
    endcase
  end

  assign status_o      = status_q;
  assign value_out_o   = 64'(vout_q);
  assign key_out_o     = 64'(kout_q);
  assign entry_total_o = TOTAL_W'(count_q);

endmodule

/* rtl/core/hkv_hash.sv */
// Iterative XXH32 (seed 0) over the key bytes: one 32x32 multiplier,
// one multiply per cycle, hash state registered. Depends on hkv_pkg.
`timescale 1ns / 1ps
module hkv_hash #(
  parameter int KEY_BYTES = hkv_pkg::KEY_BYTES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [8*KEY_BYTES-1:0] key_i,
  output logic                   done_o,
  output logic [31:0]            hash_o
);
  import hkv_pkg::*;

  localparam int KW    = 8 * KEY_BYTES;
  localparam int NW    = KEY_BYTES / 4;
  localparam int NB    = KEY_BYTES % 4;
  localparam int NSTEP = 2 * (NW + NB) + 2;
  localparam int SW    = $clog2(NSTEP + 1);

  logic [KW-1:0] key_q;
  logic [31:0]   h_q, h_d;
  logic [SW-1:0] step_q;
  logic          run_q, done_q;

  logic [SW-1:0] piece;
  logic          phase, is_word, is_fin;
  logic [3:0]    pos;
  logic [KW-1:0] chunk;
  logic [31:0]   word, op_a, op_b, prod;

  always_comb begin
    piece   = step_q >> 1;
    phase   = step_q[0];
    is_fin  = (piece == SW'(NW + NB));
    is_word = (piece < SW'(NW));
    pos     = is_word ? 4'({piece, 2'b00}) : 4'(4 * NW) + 4'(piece - SW'(NW));
    chunk   = key_q >> {pos, 3'b000};
    word    = is_word ? 32'(chunk) : {24'h0, chunk[7:0]};
    if (is_fin) begin
      op_a = phase ? (h_q ^ (h_q >> 13)) : (h_q ^ (h_q >> 15));
      op_b = phase ? PR3 : PR2;
    end else if (!phase) begin
      op_a = word;
      op_b = is_word ? PR3 : PR5;
    end else begin
      op_a = is_word ? {h_q[14:0], h_q[31:15]} : {h_q[20:0], h_q[31:21]};
      op_b = is_word ? PR4 : PR1;
    end
    prod = 32'(op_a * op_b);
    h_d  = (!is_fin && !phase) ? h_q + prod : prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == SW'(NSTEP - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      h_q   <= PR5 + 32'(KEY_BYTES);
    end else if (run_q) begin
      h_q <= h_d;
    end
  end

  assign done_o = done_q;
  assign hash_o = h_q ^ (h_q >> 16);

endmodule

/* rtl/core/hkv_store.sv */
// Slot memory: one write port, one read port with registered read data.
// Each word holds tag, key and value. No dependencies.
`timescale 1ns / 1ps
module hkv_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 136
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
